FILE: hw/rtl/twcs_pkg.sv
// ----------------------------------------------------------------------------
// twcs_pkg: shared definitions for the textured wall column span
// Screen and texture geometry, register map, codes and the command and
// status groups that join the controller to the datapath.
// ----------------------------------------------------------------------------
package twcs_pkg;

  localparam int SCREEN_WIDTH  = 1024;
  localparam int SCREEN_HEIGHT = 768;
  localparam int TEX_SIZE      = 64;

  localparam int FIX_W  = 32;
  localparam int FRAC_W = 16;
  localparam int COL_W  = 10;
  localparam int ROW_W  = 10;
  localparam int TEX_W  = $clog2(TEX_SIZE);
  localparam int SIDE_W = 2;
  localparam int MMW_W  = 11;
  localparam int MMH_W  = 10;

  localparam int DIV_W   = 48;
  localparam int MUL_W   = 49;
  localparam int MUL_ITS = 32;
  localparam int POS_LSB = FRAC_W + 1;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [DIV_W-1:0] HEIGHT_FIX  = DIV_W'(SCREEN_HEIGHT) << FRAC_W;
  localparam logic [DIV_W-1:0] TEX_SHIFT   = DIV_W'(TEX_SIZE) << FIX_W;
  localparam logic [FIX_W-1:0] MIN_PERP    = FIX_W'(7);
  localparam logic [FIX_W-1:0] FOCAL_RESET = FIX_W'(58116915);

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  localparam logic [SIDE_W-1:0] SIDE_NORTH = 2'd0;
  localparam logic [SIDE_W-1:0] SIDE_SOUTH = 2'd1;
  localparam logic [SIDE_W-1:0] SIDE_WEST  = 2'd2;
  localparam logic [SIDE_W-1:0] SIDE_EAST  = 2'd3;

  localparam logic [1:0] REG_FOCAL     = 2'd0;
  localparam logic [1:0] REG_MM_WIDTH  = 2'd1;
  localparam logic [1:0] REG_MM_HEIGHT = 2'd2;

  typedef struct packed {
    logic [FIX_W-1:0] focal_scale;
    logic [MMW_W-1:0] minimap_width;
    logic [MMH_W-1:0] minimap_height;
  } twcs_cfg_t;

  typedef struct packed {
    logic latch_start;
    logic div_go;
    logic div_sel_step;
    logic cap_h;
    logic geom;
    logic cap_step;
    logic mul_step;
    logic load_span;
    logic emit;
  } twcs_cmd_t;

  typedef struct packed {
    logic div_done;
    logic active;
  } twcs_stat_t;

endpackage

FILE: hw/rtl/twcs_regs.sv
// ----------------------------------------------------------------------------
// twcs_regs: configuration register file
// APB-style slave holding focal scale and minimap size.
// ----------------------------------------------------------------------------
module twcs_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [twcs_pkg::ADDR_W-1:0] paddr,
  input  logic [twcs_pkg::DATA_W-1:0] pwdata,
  output logic [twcs_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output twcs_pkg::twcs_cfg_t        cfg
);
  import twcs_pkg::*;

  logic [1:0] idx;
  logic       wr;

  assign idx    = paddr[ADDR_W-1:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.focal_scale    <= FOCAL_RESET;
      cfg.minimap_width  <= '0;
      cfg.minimap_height <= '0;
    end else if (wr) begin
      case (idx)
        REG_FOCAL:     cfg.focal_scale    <= pwdata;
        REG_MM_WIDTH:  cfg.minimap_width  <= pwdata[MMW_W-1:0];
        REG_MM_HEIGHT: cfg.minimap_height <= pwdata[MMH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_FOCAL:     prdata = cfg.focal_scale;
      REG_MM_WIDTH:  prdata = DATA_W'(cfg.minimap_width);
      REG_MM_HEIGHT: prdata = DATA_W'(cfg.minimap_height);
      default:       prdata = '0;
    endcase
  end

endmodule

FILE: hw/rtl/twcs_divider.sv
// ----------------------------------------------------------------------------
// twcs_divider: iterative unsigned divider
// Restoring division, one quotient bit per cycle, done pulse at the end.
// ----------------------------------------------------------------------------
module twcs_divider (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      go,
  input  logic [twcs_pkg::DIV_W-1:0] dividend,
  input  logic [twcs_pkg::DIV_W-1:0] divisor,
  output logic                      done,
  output logic [twcs_pkg::DIV_W-1:0] quotient
);
  import twcs_pkg::*;

  localparam int CNT_W = $clog2(DIV_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] dvs;
  logic [DIV_W:0]   rem_shift;
  logic [DIV_W+1:0] diff;

  assign rem_shift = {rem, quotient[DIV_W-1]};
  assign diff      = {1'b0, rem_shift} - {2'b00, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (busy) begin
      if (!diff[DIV_W+1]) begin
        rem      <= diff[DIV_W-1:0];
        quotient <= {quotient[DIV_W-2:0], 1'b1};
      end else begin
        rem      <= rem_shift[DIV_W-1:0];
        quotient <= {quotient[DIV_W-2:0], 1'b0};
      end
    end
  end

endmodule

FILE: hw/rtl/twcs_datapath.sv
// ----------------------------------------------------------------------------
// twcs_datapath: span set-up arithmetic and pixel stepping
// Wall height and texture step through the shared divider, start position
// through a shift-add multiplier, then per-pixel row and texture advance.
// ----------------------------------------------------------------------------
module twcs_datapath (
  input  logic                       clk,
  input  logic                       rst,
  input  twcs_pkg::twcs_cmd_t        cmd,
  output twcs_pkg::twcs_stat_t       stat,
  input  twcs_pkg::twcs_cfg_t        cfg,
  input  logic [twcs_pkg::FIX_W-1:0]  perp_distance,
  input  logic signed [twcs_pkg::FIX_W-1:0] hit_x,
  input  logic signed [twcs_pkg::FIX_W-1:0] hit_y,
  input  logic [twcs_pkg::SIDE_W-1:0] wall_side,
  input  logic [twcs_pkg::COL_W-1:0]  column,
  output logic [twcs_pkg::COL_W-1:0]  screen_x,
  output logic [twcs_pkg::ROW_W-1:0]  screen_y,
  output logic [twcs_pkg::TEX_W-1:0]  texel_x,
  output logic [twcs_pkg::TEX_W-1:0]  texel_y,
  output logic [twcs_pkg::SIDE_W-1:0] texture_select,
  output logic                       last
);
  import twcs_pkg::*;

  localparam int CUT_W = $clog2(SCREEN_WIDTH) + 2;
  localparam int ROW_S = ROW_W + 3;

  logic [FIX_W-1:0]  d_clamp;
  logic [DIV_W-1:0]  dvd;
  logic [DIV_W-1:0]  dvs;
  logic [DIV_W-1:0]  quo;
  logic              div_done;

  logic [DIV_W-1:0]  h;
  logic [ROW_W-1:0]  row_first;
  logic [ROW_W-1:0]  row_y1;
  logic [MUL_W-1:0]  mcand;
  logic [FIX_W-1:0]  mplier;
  logic [MUL_W-1:0]  acc;
  logic [FIX_W-1:0]  step_hold;
  logic [FIX_W-1:0]  tex_step;
  logic [FIX_W-1:0]  tex_position;
  logic [ROW_W-1:0]  row_now;
  logic [ROW_W-1:0]  row_stop;
  logic [TEX_W-1:0]  span_texel_x;
  logic [SIDE_W-1:0] span_side;
  logic [COL_W-1:0]  span_column;
  logic              active;

  logic              h_le;
  logic [DIV_W-1:0]  low_gap;
  logic [DIV_W:0]    high_sum;
  logic [DIV_W:0]    y1_wide;
  logic [ROW_W-1:0]  first_calc;
  logic [ROW_W-1:0]  y1_calc;
  logic [MUL_W-1:0]  offs_calc;
  logic [FIX_W-1:0]  step_calc;

  logic [FIX_W-1:0]  wall;
  logic [TEX_W-1:0]  tx_raw;
  logic [TEX_W-1:0]  tx_calc;

  logic              cut;
  logic signed [ROW_S-1:0] mm_bottom;
  logic signed [ROW_S-1:0] y1_s;
  logic signed [ROW_S-1:0] first_s;
  logic signed [ROW_S-1:0] stop_s;
  logic              live;

  logic [ROW_W:0]    row_inc;
  logic              at_end;

  assign d_clamp = (perp_distance < MIN_PERP) ? MIN_PERP : perp_distance;
  assign dvd     = cmd.div_sel_step ? TEX_SHIFT : {cfg.focal_scale, FRAC_W'(0)};
  assign dvs     = cmd.div_sel_step ? h : {FRAC_W'(0), d_clamp};

  twcs_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (cmd.div_go),
    .dividend (dvd),
    .divisor  (dvs),
    .done     (div_done),
    .quotient (quo)
  );

  assign stat.div_done = div_done;
  assign stat.active   = active;

  // span geometry from the wall height
  assign h_le       = h <= HEIGHT_FIX;
  assign low_gap    = HEIGHT_FIX - h;
  assign high_sum   = {1'b0, h} + {1'b0, HEIGHT_FIX};
  assign y1_wide    = high_sum >> POS_LSB;
  assign first_calc = h_le ? ROW_W'(low_gap >> POS_LSB) : '0;
  assign y1_calc    = (y1_wide > (DIV_W+1)'(SCREEN_HEIGHT - 1)) ?
                      ROW_W'(SCREEN_HEIGHT - 1) : ROW_W'(y1_wide);
  assign offs_calc  = h_le ? (MUL_W'(0) - MUL_W'(low_gap[POS_LSB-1:0])) :
                      ({1'b0, h} - {1'b0, HEIGHT_FIX});
  assign step_calc  = (|quo[DIV_W-1:FIX_W]) ? '1 : quo[FIX_W-1:0];

  assign wall    = (wall_side inside {SIDE_NORTH, SIDE_SOUTH}) ? hit_x : hit_y;
  assign tx_raw  = wall[FRAC_W-1 -: TEX_W];
  assign tx_calc = (wall_side inside {SIDE_NORTH, SIDE_EAST}) ? ~tx_raw : tx_raw;

  // minimap cut and stop row
  assign cut       = (CUT_W'(span_column) + CUT_W'(cfg.minimap_width)) >
                     CUT_W'(SCREEN_WIDTH);
  assign mm_bottom = ROW_S'(SCREEN_HEIGHT + 1) - ROW_S'(cfg.minimap_height);
  assign y1_s      = ROW_S'(row_y1);
  assign first_s   = ROW_S'(row_first);
  assign stop_s    = (cut && (mm_bottom < y1_s)) ? mm_bottom : y1_s;
  assign live      = first_s < stop_s;

  assign row_inc = {1'b0, row_now} + 1'b1;
  assign at_end  = row_inc >= {1'b0, row_stop};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (cmd.latch_start) begin
      active <= 1'b0;
    end else if (cmd.load_span) begin
      active <= live;
    end else if (cmd.emit && at_end) begin
      active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tex_position <= '0;
      tex_step     <= '0;
      row_now      <= '0;
      row_stop     <= '0;
      span_texel_x <= '0;
      span_side    <= '0;
      span_column  <= '0;
    end else begin
      if (cmd.latch_start) begin
        span_texel_x <= tx_calc;
        span_side    <= wall_side;
        span_column  <= column;
      end
      if (cmd.load_span) begin
        tex_position <= acc[POS_LSB +: FIX_W];
        tex_step     <= step_hold;
        row_now      <= row_first;
        row_stop     <= live ? ROW_W'(stop_s) : row_first;
      end else if (cmd.emit) begin
        tex_position <= tex_position + tex_step;
        row_now      <= row_inc[ROW_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_h) begin
      h <= quo;
    end
    if (cmd.geom) begin
      row_first <= first_calc;
      row_y1    <= y1_calc;
      mcand     <= offs_calc;
    end
    if (cmd.cap_step) begin
      step_hold <= step_calc;
      mplier    <= step_calc;
      acc       <= '0;
    end else if (cmd.mul_step) begin
      acc    <= acc + (mplier[0] ? mcand : MUL_W'(0));
      mcand  <= {mcand[MUL_W-2:0], 1'b0};
      mplier <= {1'b0, mplier[FIX_W-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      screen_x       <= span_column;
      screen_y       <= row_now;
      texel_x        <= span_texel_x;
      texel_y        <= tex_position[FRAC_W +: TEX_W];
      texture_select <= span_side;
      last           <= at_end;
    end
  end

endmodule

FILE: hw/rtl/twcs_ctrl.sv
// ----------------------------------------------------------------------------
// twcs_ctrl: span controller
// Sequences set-up through two divisions and the multiply, and steps pixels
// into the output register under the request and pixel handshakes.
// ----------------------------------------------------------------------------
module twcs_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  output logic                 cmd_ready,
  input  logic                 command,
  output logic                 pix_valid,
  input  logic                 pix_ready,
  input  twcs_pkg::twcs_stat_t stat,
  output twcs_pkg::twcs_cmd_t  cmd
);
  import twcs_pkg::*;

  localparam int CNT_W = $clog2(MUL_ITS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_H,
    ST_GEOM,
    ST_DIV_STEP,
    ST_MUL,
    ST_LOAD
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] mul_cnt;
  logic             accept;

  assign cmd_ready = (state == ST_IDLE) && (!pix_valid || pix_ready);
  assign accept    = cmd_valid && cmd_ready;

  always_comb begin
    cmd              = '0;
    cmd.latch_start  = accept && (command == CMD_START);
    cmd.div_sel_step = state == ST_GEOM;
    cmd.div_go       = cmd.latch_start || (state == ST_GEOM);
    cmd.cap_h        = (state == ST_DIV_H) && stat.div_done;
    cmd.geom         = state == ST_GEOM;
    cmd.cap_step     = (state == ST_DIV_STEP) && stat.div_done;
    cmd.mul_step     = state == ST_MUL;
    cmd.load_span    = state == ST_LOAD;
    cmd.emit         = accept && (command == CMD_STEP) && stat.active;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      mul_cnt   <= '0;
      pix_valid <= 1'b0;
    end else begin
      if (cmd.emit) begin
        pix_valid <= 1'b1;
      end else if (pix_ready) begin
        pix_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (cmd.latch_start) begin
            state <= ST_DIV_H;
          end
        end
        ST_DIV_H: begin
          if (stat.div_done) begin
            state <= ST_GEOM;
          end
        end
        ST_GEOM: begin
          state <= ST_DIV_STEP;
        end
        ST_DIV_STEP: begin
          if (stat.div_done) begin
            state   <= ST_MUL;
            mul_cnt <= '0;
          end
        end
        ST_MUL: begin
          mul_cnt <= mul_cnt + 1'b1;
          if (mul_cnt == CNT_W'(MUL_ITS - 1)) begin
            state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: hw/rtl/textured_wall_column_span.sv
// ----------------------------------------------------------------------------
// textured_wall_column_span: raycaster wall column span generator
// Step requests give one pixel per cycle unless pix_ready stalls the output;
//   each result sits in the output register the cycle after its request is taken.
// A start request holds the request channel through two passes of the shared
//   restoring divider and a shift-add multiply.
// Synchronous reset clears the controller, span state and configuration registers at once.
// ----------------------------------------------------------------------------
module textured_wall_column_span (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [twcs_pkg::ADDR_W-1:0]        paddr,
  input  logic [twcs_pkg::DATA_W-1:0]        pwdata,
  output logic [twcs_pkg::DATA_W-1:0]        prdata,
  output logic                              pready,
  input  logic                              cmd_valid,
  output logic                              cmd_ready,
  input  logic                              command,
  input  logic [twcs_pkg::FIX_W-1:0]         perp_distance,
  input  logic signed [twcs_pkg::FIX_W-1:0]  hit_x,
  input  logic signed [twcs_pkg::FIX_W-1:0]  hit_y,
  input  logic [twcs_pkg::SIDE_W-1:0]        wall_side,
  input  logic [twcs_pkg::COL_W-1:0]         column,
  output logic                              pix_valid,
  input  logic                              pix_ready,
  output logic [twcs_pkg::COL_W-1:0]         screen_x,
  output logic [twcs_pkg::ROW_W-1:0]         screen_y,
  output logic [twcs_pkg::TEX_W-1:0]         texel_x,
  output logic [twcs_pkg::TEX_W-1:0]         texel_y,
  output logic [twcs_pkg::SIDE_W-1:0]        texture_select,
  output logic                              last
);
  import twcs_pkg::*;

  twcs_cfg_t  cfg;
  twcs_cmd_t  cmd;
  twcs_stat_t stat;

  twcs_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  twcs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .command   (command),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  twcs_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .cfg            (cfg),
    .perp_distance  (perp_distance),
    .hit_x          (hit_x),
    .hit_y          (hit_y),
    .wall_side      (wall_side),
    .column         (column),
    .screen_x       (screen_x),
    .screen_y       (screen_y),
    .texel_x        (texel_x),
    .texel_y        (texel_y),
    .texture_select (texture_select),
    .last           (last)
  );

endmodule

FILE: hw/rtl/twcs_checker.sv
// ----------------------------------------------------------------------------
// twcs_checker: port-level checks for the column span block
// Output hold under stall, busy after start, reset and row range.
// ----------------------------------------------------------------------------
module twcs_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        cmd_valid,
  input logic                        cmd_ready,
  input logic                        command,
  input logic                        pix_valid,
  input logic                        pix_ready,
  input logic [twcs_pkg::COL_W-1:0]   screen_x,
  input logic [twcs_pkg::ROW_W-1:0]   screen_y,
  input logic [twcs_pkg::TEX_W-1:0]   texel_y,
  input logic                        last
);
  import twcs_pkg::*;

  a_pix_hold: assert property (@(posedge clk) disable iff (rst)
    pix_valid && !pix_ready |=> pix_valid && $stable(screen_x) &&
    $stable(screen_y) && $stable(texel_y) && $stable(last))
    else $error("pixel changed while stalled");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready && (command == CMD_START) |=> !cmd_ready)
    else $error("request taken during span set-up");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !pix_valid)
    else $error("pixel valid after reset");

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    pix_valid |-> screen_y < ROW_W'(SCREEN_HEIGHT - 1))
    else $error("pixel row beyond drawn area");

endmodule

bind textured_wall_column_span twcs_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_ready (cmd_ready),
  .command   (command),
  .pix_valid (pix_valid),
  .pix_ready (pix_ready),
  .screen_x  (screen_x),
  .screen_y  (screen_y),
  .texel_y   (texel_y),
  .last      (last)
);
